### rtl/matrix_vector_transform_4x4_unit_assert.svh
// ----------------------------------------------------------------------------
// matrix_vector_transform_4x4_unit assertion macros
// Concurrent assertion shorthands clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MATRIX_VECTOR_TRANSFORM_4X4_UNIT_ASSERT_SVH
`define MATRIX_VECTOR_TRANSFORM_4X4_UNIT_ASSERT_SVH

// same-cycle implication
`define MVT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mvt assertion failed");

// next-cycle implication
`define MVT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mvt assertion failed");

`endif

### rtl/mvt_pkg.sv
// ----------------------------------------------------------------------------
// mvt_pkg
// Shared types and constants of the 4x4 Q16.16 matrix-vector transform.
// ----------------------------------------------------------------------------
package mvt_pkg;

  localparam int N_AXES  = 4;
  localparam int WORD_W  = 32;
  localparam int FRAC_W  = 16;
  localparam int PROD_W  = 2 * WORD_W;
  localparam int PAIR_W  = PROD_W + 1;
  localparam int SUM_W   = PROD_W + 2;
  localparam int RND_W   = SUM_W - FRAC_W;
  localparam int REG_W   = 2 * WORD_W;
  localparam int ADDR_W  = 3;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef word_t vec_t [N_AXES];

  localparam word_t ONE_Q16 = word_t'(1 << FRAC_W);
  localparam word_t SAT_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam word_t SAT_MIN = {1'b1, {(WORD_W-1){1'b0}}};
  localparam logic signed [SUM_W-1:0] RND_HALF = SUM_W'(1) <<< (FRAC_W - 1);

  typedef struct packed {
    word_t value;
    logic  sat;
  } lane_res_t;

  typedef struct packed {
    logic adv;
    logic vld;
  } pipe_ctl_t;

endpackage

### rtl/mvt_lane.sv
// ----------------------------------------------------------------------------
// mvt_lane
// One output component: four products, pair sums, round and saturate.
// ----------------------------------------------------------------------------
module mvt_lane (
  input  logic               clk,
  input  logic               en,
  input  mvt_pkg::vec_t      vec_i,
  input  mvt_pkg::vec_t      col_i,
  output mvt_pkg::lane_res_t res_o
);

  logic signed [mvt_pkg::PROD_W-1:0] prod_r [mvt_pkg::N_AXES];
  logic signed [mvt_pkg::PROD_W-1:0] prod_nxt [mvt_pkg::N_AXES];
  logic signed [mvt_pkg::PAIR_W-1:0] pair_r [2];
  logic signed [mvt_pkg::PAIR_W-1:0] pair_nxt [2];
  logic signed [mvt_pkg::SUM_W-1:0]  sum;
  logic signed [mvt_pkg::RND_W-1:0]  rnd;
  mvt_pkg::lane_res_t                res_r;
  mvt_pkg::lane_res_t                res_nxt;
  logic                              ovf_hi;
  logic                              ovf_lo;

  always_comb begin
    for (int a = 0; a < mvt_pkg::N_AXES; a++) begin
      prod_nxt[a] = mvt_pkg::PROD_W'(vec_i[a]) * mvt_pkg::PROD_W'(col_i[a]);
    end
    pair_nxt[0] = mvt_pkg::PAIR_W'(prod_r[0]) + mvt_pkg::PAIR_W'(prod_r[1]);
    pair_nxt[1] = mvt_pkg::PAIR_W'(prod_r[2]) + mvt_pkg::PAIR_W'(prod_r[3]);
  end

  // add one half lsb, then floor by dropping the fraction bits
  always_comb begin
    sum    = mvt_pkg::SUM_W'(pair_r[0]) + mvt_pkg::SUM_W'(pair_r[1]) + mvt_pkg::RND_HALF;
    rnd    = sum[mvt_pkg::SUM_W-1:mvt_pkg::FRAC_W];
    ovf_hi = rnd > mvt_pkg::RND_W'(mvt_pkg::SAT_MAX);
    ovf_lo = rnd < mvt_pkg::RND_W'(mvt_pkg::SAT_MIN);
    res_nxt.sat = ovf_hi | ovf_lo;
    if (ovf_hi) begin
      res_nxt.value = mvt_pkg::SAT_MAX;
    end else if (ovf_lo) begin
      res_nxt.value = mvt_pkg::SAT_MIN;
    end else begin
      res_nxt.value = rnd[mvt_pkg::WORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
      pair_r <= pair_nxt;
      res_r  <= res_nxt;
    end
  end

  assign res_o = res_r;

endmodule

### rtl/mvt_merge.sv
// ----------------------------------------------------------------------------
// mvt_merge
// Output register: gathers the four lane results and ORs their clip flags.
// ----------------------------------------------------------------------------
module mvt_merge (
  input  logic               clk,
  input  logic               rst_n,
  input  mvt_pkg::pipe_ctl_t ctl_i,
  input  mvt_pkg::lane_res_t lane_i [mvt_pkg::N_AXES],
  output logic               out_valid,
  output mvt_pkg::word_t     out_x,
  output mvt_pkg::word_t     out_y,
  output mvt_pkg::word_t     out_z,
  output mvt_pkg::word_t     out_w,
  output logic               out_saturated
);

  mvt_pkg::word_t comp_r [mvt_pkg::N_AXES];
  logic           sat_r;
  logic           sat_nxt;
  logic           valid_r;

  always_comb begin
    sat_nxt = 1'b0;
    for (int c = 0; c < mvt_pkg::N_AXES; c++) begin
      sat_nxt = sat_nxt | lane_i[c].sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl_i.adv) begin
      valid_r <= ctl_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_i.adv) begin
      for (int c = 0; c < mvt_pkg::N_AXES; c++) begin
        comp_r[c] <= lane_i[c].value;
      end
      sat_r <= sat_nxt;
    end
  end

  assign out_valid     = valid_r;
  assign out_x         = comp_r[0];
  assign out_y         = comp_r[1];
  assign out_z         = comp_r[2];
  assign out_w         = comp_r[3];
  assign out_saturated = sat_r;

endmodule

### rtl/matrix_vector_transform_4x4_unit.sv
// Registers: lane product, pair sum and lane result, then the merge output register.
// Throughput: one transaction per cycle; the four lanes each hold four 32x32
// multipliers and the pipeline advances whenever the output register is free.
// A stalled output holds the whole pipeline, and in_stall follows it.
// Reset (synchronous, rst_n low) empties the pipeline and loads the identity matrix.
// ----------------------------------------------------------------------------
// matrix_vector_transform_4x4_unit
// Q16.16 affine transform of a four-component vector by a configured 4x4 matrix.
// ----------------------------------------------------------------------------
module matrix_vector_transform_4x4_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [mvt_pkg::ADDR_W-1:0]  cfg_addr,
  input  logic [mvt_pkg::REG_W-1:0]   cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_kind,
  input  mvt_pkg::word_t              in_x,
  input  mvt_pkg::word_t              in_y,
  input  mvt_pkg::word_t              in_z,
  input  mvt_pkg::word_t              in_w,
  output logic                        out_valid,
  input  logic                        out_stall,
  output mvt_pkg::word_t              out_x,
  output mvt_pkg::word_t              out_y,
  output mvt_pkg::word_t              out_z,
  output mvt_pkg::word_t              out_w,
  output logic                        out_saturated
);

  // axis_r[a][c]: component c of axis a
  mvt_pkg::word_t     axis_r [mvt_pkg::N_AXES][mvt_pkg::N_AXES];
  mvt_pkg::vec_t      vec;
  mvt_pkg::vec_t      col [mvt_pkg::N_AXES];
  mvt_pkg::lane_res_t lane_res [mvt_pkg::N_AXES];
  mvt_pkg::pipe_ctl_t merge_ctl;
  logic               adv;
  logic               v1_r;
  logic               v2_r;
  logic               v3_r;

  // configuration: register 2a+h holds axis a, components 2h and 2h+1
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < mvt_pkg::N_AXES; a++) begin
        for (int c = 0; c < mvt_pkg::N_AXES; c++) begin
          axis_r[a][c] <= (a == c) ? mvt_pkg::ONE_Q16 : '0;
        end
      end
    end else if (cfg_wr_en) begin
      for (int a = 0; a < mvt_pkg::N_AXES; a++) begin
        for (int c = 0; c < mvt_pkg::N_AXES; c++) begin
          if (cfg_addr[mvt_pkg::ADDR_W-1:1] == 2'(a) && cfg_addr[0] == 1'(c >> 1)) begin
            axis_r[a][c] <= (c % 2 == 1) ? cfg_wdata[mvt_pkg::REG_W-1:mvt_pkg::WORD_W]
                                         : cfg_wdata[mvt_pkg::WORD_W-1:0];
          end
        end
      end
    end
  end

  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  always_comb begin
    vec[0] = in_x;
    vec[1] = in_y;
    vec[2] = in_z;
    vec[3] = in_kind ? mvt_pkg::ONE_Q16 : in_w;
    for (int c = 0; c < mvt_pkg::N_AXES; c++) begin
      for (int a = 0; a < mvt_pkg::N_AXES; a++) begin
        col[c][a] = axis_r[a][c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  for (genvar g = 0; g < mvt_pkg::N_AXES; g++) begin : g_lane
    mvt_lane u_lane (
      .clk   (clk),
      .en    (adv),
      .vec_i (vec),
      .col_i (col[g]),
      .res_o (lane_res[g])
    );
  end

  assign merge_ctl.adv = adv;
  assign merge_ctl.vld = v3_r;

  mvt_merge u_merge (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl_i         (merge_ctl),
    .lane_i        (lane_res),
    .out_valid     (out_valid),
    .out_x         (out_x),
    .out_y         (out_y),
    .out_z         (out_z),
    .out_w         (out_w),
    .out_saturated (out_saturated)
  );

`include "matrix_vector_transform_4x4_unit_assert.svh"

  `MVT_ASSERT_NXT(a_accept_enters, in_valid && !in_stall, v1_r)
  `MVT_ASSERT_NXT(a_stall_holds_last, v3_r && out_valid && out_stall, v3_r && out_valid)
  `MVT_ASSERT_NXT(a_drain_empties, out_valid && !out_stall && !v3_r, !out_valid)
  `MVT_ASSERT_IMP(a_sat_clipped, out_valid && out_saturated,
    out_x == mvt_pkg::SAT_MAX || out_x == mvt_pkg::SAT_MIN ||
    out_y == mvt_pkg::SAT_MAX || out_y == mvt_pkg::SAT_MIN ||
    out_z == mvt_pkg::SAT_MAX || out_z == mvt_pkg::SAT_MIN ||
    out_w == mvt_pkg::SAT_MAX || out_w == mvt_pkg::SAT_MIN)

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Q16.16 4x4 matrix-vector transform. A local
// model of the matrix predicts each vector as it is accepted; a monitor
// compares every output transaction, in order, against those predictions.
// Both channels idle and stall at random between directed and random tests.
// ----------------------------------------------------------------------------
module tb;

  localparam int LATENCY   = 4;
  localparam int LONG_HOLD = 60;
  localparam int MAX_IDLE  = 10;
  localparam int LIMIT     = 200000;

  typedef enum logic {KIND_VECTOR = 1'b0, KIND_POINT = 1'b1} kind_t;

  typedef enum logic [mvt_pkg::ADDR_W-1:0] {
    AXIS_X_LO, AXIS_X_HI, AXIS_Y_LO, AXIS_Y_HI,
    AXIS_Z_LO, AXIS_Z_HI, AXIS_W_LO, AXIS_W_HI
  } cfg_reg_t;

  // matrix indexed [axis][component]
  typedef mvt_pkg::word_t mat_t [mvt_pkg::N_AXES][mvt_pkg::N_AXES];

  typedef struct {
    mvt_pkg::word_t comp [mvt_pkg::N_AXES];
    logic           sat;
  } xform_res_t;

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       cfg_wr_en;
  logic [mvt_pkg::ADDR_W-1:0] cfg_addr;
  logic [mvt_pkg::REG_W-1:0]  cfg_wdata;
  logic                       in_valid;
  logic                       in_stall;
  logic                       in_kind;
  mvt_pkg::word_t             in_x, in_y, in_z, in_w;
  logic                       out_valid;
  logic                       out_stall;
  mvt_pkg::word_t             out_x, out_y, out_z, out_w;
  logic                       out_saturated;

  mat_t              mat;
  xform_res_t        pending_vectors [$];
  int                errors;
  int                cycle_count;
  logic              tx_idle;
  logic              rx_idle;
  logic              long_hold_req;

  matrix_vector_transform_4x4_unit DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_kind       (in_kind),
    .in_x          (in_x),
    .in_y          (in_y),
    .in_z          (in_z),
    .in_w          (in_w),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_x         (out_x),
    .out_y         (out_y),
    .out_z         (out_z),
    .out_w         (out_w),
    .out_saturated (out_saturated)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // prediction
  // --------------------------------------------------------------------------
  function automatic xform_res_t transform(kind_t kind, mvt_pkg::word_t vx,
                                           mvt_pkg::word_t vy, mvt_pkg::word_t vz,
                                           mvt_pkg::word_t vw);
    mvt_pkg::word_t     v [mvt_pkg::N_AXES];
    logic signed [67:0] acc;
    longint             q;
    xform_res_t         r;
    v[0] = vx;
    v[1] = vy;
    v[2] = vz;
    v[3] = (kind == KIND_POINT) ? mvt_pkg::ONE_Q16 : vw;
    r.sat = 1'b0;
    for (int c = 0; c < mvt_pkg::N_AXES; c++) begin
      acc = '0;
      for (int a = 0; a < mvt_pkg::N_AXES; a++) begin
        acc = acc + v[a] * mat[a][c];
      end
      // round half up, then floor onto the Q16.16 grid
      acc = acc + 68'sd32768;
      q = longint'(acc >>> 16);
      if (q > longint'(mvt_pkg::SAT_MAX)) begin
        r.comp[c] = mvt_pkg::SAT_MAX;
        r.sat = 1'b1;
      end else if (q < longint'(mvt_pkg::SAT_MIN)) begin
        r.comp[c] = mvt_pkg::SAT_MIN;
        r.sat = 1'b1;
      end else begin
        r.comp[c] = mvt_pkg::word_t'(q);
      end
    end
    return r;
  endfunction

  function automatic mat_t identity_mat();
    mat_t m;
    for (int a = 0; a < mvt_pkg::N_AXES; a++)
      for (int c = 0; c < mvt_pkg::N_AXES; c++)
        m[a][c] = (a == c) ? mvt_pkg::ONE_Q16 : '0;
    return m;
  endfunction

  function automatic mat_t uniform_mat(mvt_pkg::word_t v);
    mat_t m;
    for (int a = 0; a < mvt_pkg::N_AXES; a++)
      for (int c = 0; c < mvt_pkg::N_AXES; c++)
        m[a][c] = v;
    return m;
  endfunction

  function automatic mvt_pkg::word_t rand_word();
    case ($urandom_range(0, 4))
      0: return mvt_pkg::word_t'($urandom);
      1: return mvt_pkg::word_t'(int'($urandom_range(0, 32'h80000)) - 32'sh40000);
      2: begin
        case ($urandom_range(0, 4))
          0: return mvt_pkg::SAT_MAX;
          1: return mvt_pkg::SAT_MIN;
          2: return mvt_pkg::ONE_Q16;
          3: return -mvt_pkg::ONE_Q16;
          default: return '0;
        endcase
      end
      3: return mvt_pkg::word_t'(int'($urandom_range(0, 32'h20000)) - 32'sh10000);
      default: return mvt_pkg::word_t'(int'($urandom_range(0, 255)) - 128);
    endcase
  endfunction

  function automatic mat_t rand_mat(bit full_range);
    mat_t m;
    for (int a = 0; a < mvt_pkg::N_AXES; a++)
      for (int c = 0; c < mvt_pkg::N_AXES; c++)
        m[a][c] = full_range ? mvt_pkg::word_t'($urandom) : rand_word();
    return m;
  endfunction

  // --------------------------------------------------------------------------
  // drivers
  // --------------------------------------------------------------------------
  task automatic load_matrix(input mat_t m);
    cfg_reg_t r;
    int       a;
    int       h;
    r = r.first();
    repeat (2 * mvt_pkg::N_AXES) begin
      a = int'(r) >> 1;
      h = (int'(r) & 1) * 2;
      cfg_wr_en <= 1'b1;
      cfg_addr  <= r;
      cfg_wdata <= {m[a][h+1], m[a][h]};
      @(posedge clk);
      r = r.next();
    end
    cfg_wr_en <= 1'b0;
    mat = m;
  endtask

  task automatic send_vec(input kind_t kind, input mvt_pkg::word_t vx,
                          input mvt_pkg::word_t vy, input mvt_pkg::word_t vz,
                          input mvt_pkg::word_t vw);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind  <= kind;
    in_x     <= vx;
    in_y     <= vy;
    in_z     <= vz;
    in_w     <= vw;
    do @(posedge clk); while (in_stall);
    pending_vectors.push_back(transform(kind, vx, vy, vz, vw));
  endtask

  task automatic send_random_vec();
    send_vec(kind_t'($urandom_range(0, 1)), rand_word(), rand_word(),
             rand_word(), rand_word());
  endtask

  // drop valid and let every outstanding transaction come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_vectors.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  // receiver: random stall before each result, or one long hold on request
  initial begin : result_sink
    int unsigned n;
    out_stall = 1'b0;
    forever begin
      if (long_hold_req) begin
        n = LONG_HOLD;
        long_hold_req = 1'b0;
      end else begin
        n = rx_idle ? $urandom_range(0, MAX_IDLE) : 0;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // --------------------------------------------------------------------------
  // result checking
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    xform_res_t     want;
    mvt_pkg::word_t got [mvt_pkg::N_AXES];
    if (rst_n && out_valid && !out_stall) begin
      got[0] = out_x;
      got[1] = out_y;
      got[2] = out_z;
      got[3] = out_w;
      if (pending_vectors.size() == 0) begin
        errors++;
        $display("%0t: unexpected transaction %h %h %h %h sat %b", $time,
                 out_x, out_y, out_z, out_w, out_saturated);
      end else begin
        want = pending_vectors.pop_front();
        for (int c = 0; c < mvt_pkg::N_AXES; c++) begin
          if (got[c] !== want.comp[c]) begin
            errors++;
            $display("%0t: component %0d expected %h got %h", $time, c,
                     want.comp[c], got[c]);
          end
        end
        if (out_saturated !== want.sat) begin
          errors++;
          $display("%0t: saturated expected %b got %b", $time, want.sat,
                   out_saturated);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------
  // reset matrix is the identity; point mode replaces w with one
  task automatic test_reset_identity();
    send_vec(KIND_VECTOR, '0, '0, '0, '0);
    send_vec(KIND_VECTOR, mvt_pkg::SAT_MAX, mvt_pkg::SAT_MIN, mvt_pkg::ONE_Q16,
             -mvt_pkg::ONE_Q16);
    send_vec(KIND_POINT, 32'sh10000, 32'sh20000, 32'sh30000, mvt_pkg::SAT_MIN);
    send_vec(KIND_POINT, mvt_pkg::SAT_MAX, mvt_pkg::SAT_MAX, mvt_pkg::SAT_MAX,
             32'sh5a5a5a5a);
    send_vec(KIND_VECTOR, mvt_pkg::SAT_MIN, mvt_pkg::SAT_MIN, mvt_pkg::SAT_MIN,
             mvt_pkg::SAT_MAX);
    wait_idle();
  endtask

  // fractional weights so single-lsb inputs land on halves and quarters
  task automatic test_rounding_ties();
    mat_t m;
    m = uniform_mat('0);
    m[0][0] = 32'sh8000;
    m[0][1] = 32'sh4000;
    m[0][2] = 32'shc000;
    m[0][3] = -32'sh8000;
    load_matrix(m);
    send_vec(KIND_VECTOR, 32'sd1, '0, '0, '0);
    send_vec(KIND_VECTOR, -32'sd1, '0, '0, '0);
    send_vec(KIND_VECTOR, 32'sd3, '0, '0, '0);
    send_vec(KIND_VECTOR, -32'sd3, '0, '0, '0);
    send_vec(KIND_VECTOR, mvt_pkg::SAT_MAX, '0, '0, '0);
    send_vec(KIND_POINT, mvt_pkg::SAT_MIN, '0, '0, mvt_pkg::SAT_MAX);
    wait_idle();
  endtask

  task automatic test_saturation();
    mat_t m;
    load_matrix(uniform_mat(mvt_pkg::SAT_MAX));
    send_vec(KIND_VECTOR, mvt_pkg::SAT_MAX, mvt_pkg::SAT_MAX, mvt_pkg::SAT_MAX,
             mvt_pkg::SAT_MAX);
    send_vec(KIND_VECTOR, mvt_pkg::SAT_MIN, mvt_pkg::SAT_MIN, mvt_pkg::SAT_MIN,
             mvt_pkg::SAT_MIN);
    send_vec(KIND_POINT, '0, '0, '0, mvt_pkg::SAT_MIN);
    wait_idle();
    // largest possible sum: every product is 2^62
    load_matrix(uniform_mat(mvt_pkg::SAT_MIN));
    send_vec(KIND_VECTOR, mvt_pkg::SAT_MIN, mvt_pkg::SAT_MIN, mvt_pkg::SAT_MIN,
             mvt_pkg::SAT_MIN);
    send_vec(KIND_VECTOR, mvt_pkg::SAT_MAX, mvt_pkg::SAT_MAX, mvt_pkg::SAT_MAX,
             mvt_pkg::SAT_MAX);
    send_vec(KIND_VECTOR, '0, '0, '0, '0);
    wait_idle();
    // out_x = x + y: one lsb either side of the limits
    m = identity_mat();
    m[1][0] = mvt_pkg::ONE_Q16;
    load_matrix(m);
    send_vec(KIND_VECTOR, mvt_pkg::SAT_MAX, '0, '0, '0);
    send_vec(KIND_VECTOR, mvt_pkg::SAT_MAX, 32'sd1, '0, '0);
    send_vec(KIND_VECTOR, mvt_pkg::SAT_MIN, '0, '0, '0);
    send_vec(KIND_VECTOR, mvt_pkg::SAT_MIN, -32'sd1, '0, '0);
    wait_idle();
  endtask

  task automatic test_random_matrices();
    for (int p = 0; p < 6; p++) begin
      load_matrix(rand_mat(p == 0));
      for (int i = 0; i < 55; i++) begin
        if (i % 15 == 0) begin
          tx_idle = ($urandom_range(0, 3) != 0);
          rx_idle = ($urandom_range(0, 3) != 0);
        end
        // sender holds off until the pipeline has drained
        if (i == 27 && p == 2) wait_idle();
        send_random_vec();
      end
      wait_idle();
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  task automatic test_full_throughput();
    load_matrix(rand_mat(1'b0));
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    repeat (60) send_random_vec();
    wait_idle();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  // long output stall while the sender keeps offering: pipeline fills up
  task automatic test_output_backpressure();
    load_matrix(rand_mat(1'b0));
    tx_idle = 1'b0;
    rx_idle = 1'b1;
    long_hold_req = 1'b1;
    repeat (45) send_random_vec();
    wait_idle();
    tx_idle = 1'b1;
  endtask

  initial begin
    rst_n         = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_addr      = '0;
    cfg_wdata     = '0;
    in_valid      = 1'b0;
    in_kind       = KIND_VECTOR;
    in_x          = '0;
    in_y          = '0;
    in_z          = '0;
    in_w          = '0;
    tx_idle       = 1'b1;
    rx_idle       = 1'b1;
    long_hold_req = 1'b0;
    errors        = 0;
    cycle_count   = 0;
    mat           = identity_mat();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_identity();
    test_rounding_ties();
    test_saturation();
    test_random_matrices();
    test_full_throughput();
    test_output_backpressure();

    wait_idle();
    repeat (2 * LATENCY) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
